// ===== rtl/core/djs_pkg.sv =====
// Package for the deadline job sequencer: sizes and item types.
`timescale 1ns / 1ps
package djs_pkg;

  localparam int unsigned MaxJobs  = 1024;
  localparam int unsigned MaxSlots = 1024;
  localparam int unsigned JobAw    = $clog2(MaxJobs);
  localparam int unsigned SlotAw   = $clog2(MaxSlots);
  localparam int unsigned CntW     = JobAw + 1;
  localparam int unsigned DlW      = SlotAw + 1;

  typedef struct packed {
    logic [15:0] deadline;
    logic [15:0] profit;
    logic        last_job;
  } job_in_t;

  typedef struct packed {
    logic [10:0] jobs_done;
    logic [25:0] total_profit;
    logic        overflow;
  } job_out_t;

  typedef struct packed {
    logic           used;
    logic [DlW-1:0] dl;
    logic [15:0]    pr;
  } job_ent_t;

endpackage

// ===== rtl/core/deadline_job_sequencer.sv =====
// Greedy job sequencer with deadlines: job store, selection scan, slot search.
// Load: one item per cycle while busy is low; an item with last_job starts the burst.
// Burst: per job a scan of the stored jobs, one mark state, then a slot read and a slot check state
// per slot probed, from the deadline slot downward; the last scan ends in the result.
// A clear of all MaxSlots slots starts with the result strobe and also runs after reset.
// Results are one-cycle strobes; the receiver cannot stall.
`timescale 1ns / 1ps
module deadline_job_sequencer import djs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  job_in_t  job_i,
  output logic     result_valid_o,
  output job_out_t result_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MARK, ST_SLOT_RD, ST_SLOT_CHK, ST_CLEAR
  } state_e;

  state_e state_q;
  logic [CntW-1:0]   cnt_q, idx_q;
  logic              ovf_q, rv_q, found_q;
  logic [JobAw-1:0]  ridx_q, bidx_q;
  job_ent_t          best_q;
  logic [DlW-1:0]    k_q;
  logic [10:0]       done_q;
  logic [25:0]       sum_q;
  logic [SlotAw-1:0] clr_q;

  job_ent_t          jmem [MaxJobs];
  logic              smem [MaxSlots];
  job_ent_t          jrd_q;
  logic              srd_q;

  logic              jwe, swe, swdata;
  logic [JobAw-1:0]  jwaddr, jraddr;
  job_ent_t          jwdata;
  logic [SlotAw-1:0] swaddr, sraddr;
  logic              accept;
  logic [DlW-1:0]    dl_clamp;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign dl_clamp = (job_i.deadline > 16'(MaxSlots)) ? DlW'(MaxSlots)
                                                      : DlW'(job_i.deadline);

  always_comb begin
    jwe    = 1'b0;
    jwaddr = cnt_q[JobAw-1:0];
    jwdata = '{used: 1'b0, dl: dl_clamp, pr: job_i.profit};
    jraddr = idx_q[JobAw-1:0];
    swe    = 1'b0;
    swaddr = clr_q;
    swdata = 1'b0;
    sraddr = SlotAw'(k_q - DlW'(1));
    case (state_q)
      ST_IDLE: begin
        jwe = accept && (cnt_q < CntW'(MaxJobs));
      end
      ST_MARK: begin
        jwe         = 1'b1;
        jwaddr      = bidx_q;
        jwdata      = best_q;
        jwdata.used = 1'b1;
      end
      ST_SLOT_CHK: begin
        swe    = !srd_q;
        swaddr = sraddr;
        swdata = 1'b1;
      end
      ST_CLEAR: begin
        swe = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (jwe) jmem[jwaddr] <= jwdata;
    jrd_q <= jmem[jraddr];
  end

  always_ff @(posedge clk_i) begin
    if (swe) smem[swaddr] <= swdata;
    srd_q <= smem[sraddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      cnt_q          <= '0;
      idx_q          <= '0;
      ovf_q          <= 1'b0;
      rv_q           <= 1'b0;
      found_q        <= 1'b0;
      ridx_q         <= '0;
      bidx_q         <= '0;
      best_q         <= '0;
      k_q            <= '0;
      done_q         <= '0;
      sum_q          <= '0;
      clr_q          <= '0;
      result_valid_o <= 1'b0;
      result_o       <= '0;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (cnt_q < CntW'(MaxJobs)) cnt_q <= cnt_q + CntW'(1);
            else                        ovf_q <= 1'b1;
            if (job_i.last_job) begin
              state_q <= ST_SCAN;
              idx_q   <= '0;
              rv_q    <= 1'b0;
              found_q <= 1'b0;
              done_q  <= '0;
              sum_q   <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (idx_q < cnt_q) begin
            idx_q  <= idx_q + CntW'(1);
            rv_q   <= 1'b1;
            ridx_q <= idx_q[JobAw-1:0];
          end else begin
            rv_q <= 1'b0;
          end
          if (rv_q && !jrd_q.used && (!found_q || jrd_q.pr > best_q.pr)) begin
            found_q <= 1'b1;
            best_q  <= jrd_q;
            bidx_q  <= ridx_q;
          end
          if (idx_q >= cnt_q && !rv_q) begin
            if (found_q) begin
              state_q <= ST_MARK;
            end else begin
              result_valid_o        <= 1'b1;
              result_o.jobs_done    <= done_q;
              result_o.total_profit <= sum_q;
              result_o.overflow     <= ovf_q;
              state_q               <= ST_CLEAR;
              clr_q                 <= '0;
            end
          end
        end
        ST_MARK: begin
          idx_q   <= '0;
          rv_q    <= 1'b0;
          found_q <= 1'b0;
          k_q     <= best_q.dl;
          state_q <= (best_q.dl == '0) ? ST_SCAN : ST_SLOT_RD;
        end
        ST_SLOT_RD: begin
          state_q <= ST_SLOT_CHK;
        end
        ST_SLOT_CHK: begin
          if (!srd_q) begin
            done_q  <= done_q + 11'd1;
            sum_q   <= sum_q + 26'(best_q.pr);
            state_q <= ST_SCAN;
          end else if (k_q == DlW'(1)) begin
            state_q <= ST_SCAN;
          end else begin
            k_q     <= k_q - DlW'(1);
            state_q <= ST_SLOT_RD;
          end
        end
        ST_CLEAR: begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
          clr_q <= clr_q + SlotAw'(1);
          if (clr_q == SlotAw'(MaxSlots - 1)) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/deadline_job_sequencer_test.sv =====
// Testbench for deadline_job_sequencer: directed and random job sets checked against a scheduler.
`timescale 1ns / 1ps
module deadline_job_sequencer_test;
  import djs_pkg::*;

  localparam int unsigned CycleLimit = 8000000;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  job_in_t  job_i;
  logic     result_valid_o;
  job_out_t result_o;

  deadline_job_sequencer dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .job_i(job_i),
    .result_valid_o(result_valid_o),
    .result_o(result_o)
  );

  job_out_t    sched_q[$];
  logic [15:0] set_dl[MaxJobs];
  logic [15:0] set_pr[MaxJobs];
  int unsigned set_cnt;
  bit          set_ovf;
  int unsigned errors;
  int unsigned cycles;
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("deadline_job_sequencer_test: errors");
      $finish;
    end
  end

  // Greedy schedule of the collected set; profits sorted high first, stable.
  function automatic job_out_t schedule_set();
    job_out_t    r;
    int unsigned ord[MaxJobs];
    bit          taken[MaxSlots];
    int unsigned cur;
    int          j;
    int          k;
    r = '0;
    for (int i = 0; i < MaxSlots; i++) taken[i] = 1'b0;
    for (int i = 0; i < set_cnt; i++) ord[i] = i;
    for (int i = 1; i < set_cnt; i++) begin
      cur = ord[i];
      j = i;
      while (j > 0 && set_pr[ord[j-1]] < set_pr[cur]) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = cur;
    end
    for (int i = 0; i < set_cnt; i++) begin
      k = (int'(set_dl[ord[i]]) > int'(MaxSlots)) ? int'(MaxSlots) : int'(set_dl[ord[i]]);
      while (k > 0) begin
        if (!taken[k-1]) begin
          taken[k-1] = 1'b1;
          r.jobs_done = r.jobs_done + 11'd1;
          r.total_profit = r.total_profit + 26'(set_pr[ord[i]]);
          break;
        end
        k--;
      end
    end
    r.overflow = set_ovf;
    return r;
  endfunction

  task automatic accept_job(job_in_t j);
    if (set_cnt < MaxJobs) begin
      set_dl[set_cnt] = j.deadline;
      set_pr[set_cnt] = j.profit;
      set_cnt++;
    end else begin
      set_ovf = 1'b1;
    end
    if (j.last_job) begin
      sched_q = {sched_q, schedule_set()};
      set_cnt = 0;
      set_ovf = 1'b0;
    end
  endtask

  task automatic send_job(logic [15:0] dl, logic [15:0] pr, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        start = 1'b0;
        job_i = '0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    start = 1'b1;
    job_i.deadline = dl;
    job_i.profit = pr;
    job_i.last_job = last;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    accept_job(job_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (sched_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result_o);
        errors++;
      end else begin
        job_out_t e;
        e = sched_q.pop_front();
        if (result_o.jobs_done !== e.jobs_done) begin
          $display("%0t: jobs_done exp %0d got %0d", $time, e.jobs_done, result_o.jobs_done);
          errors++;
        end
        if (result_o.total_profit !== e.total_profit) begin
          $display("%0t: total_profit exp %0d got %0d", $time, e.total_profit,
                   result_o.total_profit);
          errors++;
        end
        if (result_o.overflow !== e.overflow) begin
          $display("%0t: overflow exp %0b got %0b", $time, e.overflow, result_o.overflow);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_job(16'd0, 16'hFFFF, 1'b1);
    send_job(16'hFFFF, 16'hFFFF, 1'b1);
    send_job(16'd1024, 16'd7, 1'b0);
    send_job(16'd1025, 16'd7, 1'b0);
    send_job(16'd0, 16'd0, 1'b0);
    send_job(16'd1, 16'd0, 1'b1);
    // equal profits competing for the same slots
    send_job(16'd2, 16'd50, 1'b0);
    send_job(16'd2, 16'd50, 1'b0);
    send_job(16'd2, 16'd50, 1'b0);
    send_job(16'd1, 16'd60, 1'b1);
    send_job(16'd1, 16'd10, 1'b0);
    send_job(16'd1, 16'd20, 1'b0);
    send_job(16'd3, 16'h8000, 1'b0);
    send_job(16'd0, 16'hFFFF, 1'b0);
    send_job(16'h8000, 16'h5555, 1'b0);
    send_job(16'h7FFF, 16'hAAAA, 1'b1);
  endtask

  // Deadline 1 keeps the slot search short on a full store.
  task automatic test_overflow();
    for (int i = 0; i < MaxJobs + 6; i++)
      send_job(16'd1, 16'($urandom), i == MaxJobs + 5);
  endtask

  task automatic test_random();
    int unsigned n;
    int unsigned sent;
    logic [15:0] dl;
    sent = 0;
    while (sent < 200) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 5))
          0: dl = 16'($urandom);
          1: dl = 16'd0;
          default: dl = 16'($urandom_range(1, n + 2));
        endcase
        send_job(dl, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom),
                 i == n - 1);
      end
      sent += n;
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    set_cnt = 0;
    set_ovf = 1'b0;
    burst_left = 0;
    start = 1'b0;
    job_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_overflow();
    test_random();
    @(negedge clk_i);
    start = 1'b0;
    job_i = '0;
    while (sched_q.size() != 0) @(posedge clk_i);
    repeat (2 * MaxSlots) @(posedge clk_i);
    if (errors == 0) begin
      $display("deadline_job_sequencer_test: clean");
    end else begin
      $display("deadline_job_sequencer_test: errors");
    end
    $finish;
  end

endmodule
